>>> rtl/bffa_pkg.sv
package bffa_pkg;

   // Bitmap geometry
   localparam int BITMAP_BYTES = 4096;
   localparam int POOL_BITS    = BITMAP_BYTES * 8;
   localparam int BYTE_ADDR_W  = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
   localparam int BIT_IDX_W    = BYTE_ADDR_W + 3;
   localparam int HWM_W        = $clog2(BITMAP_BYTES + 1);

   // Request codes
   localparam logic [1:0] REQ_ALLOC_BLOCK = 2'd0;
   localparam logic [1:0] REQ_FREE_BLOCK  = 2'd1;
   localparam logic [1:0] REQ_ALLOC_INODE = 2'd2;
   localparam logic [1:0] REQ_FREE_INODE  = 2'd3;

   // Status codes
   localparam logic [1:0] STAT_OK           = 2'd0;
   localparam logic [1:0] STAT_FULL         = 2'd1;
   localparam logic [1:0] STAT_ALREADY_FREE = 2'd2;
   localparam logic [1:0] STAT_RANGE        = 2'd3;

endpackage

>>> rtl/bffa_ram.sv
module bffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bitmap_first_free_allocator.sv
// Allocate: one bitmap byte is read per cycle, up to BITMAP_BYTES bytes, and each is
// checked after its read; the strobe follows the first byte with a clear bit, or the
// last byte when the pool is full. Free: offset, byte read, byte check, result; an
// out-of-range number skips the read and check. busy drops in the strobe cycle, so the
// next start is taken there; the receiver cannot stall the strobe.
// Reset is synchronous; both bitmaps read as empty right away (no clearing pass).
module bitmap_first_free_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_item_number,
   output logic        rsp_strobe,
   output logic [31:0] rsp_alloc_number,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_base_block
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_OFFSET   = 3'd1;
   localparam logic [2:0] ST_SCAN     = 3'd2;
   localparam logic [2:0] ST_FREE_RD  = 3'd3;
   localparam logic [2:0] ST_FREE_CHK = 3'd4;
   localparam logic [2:0] ST_RESULT   = 3'd5;

   localparam int AW = bffa_pkg::BYTE_ADDR_W;
   localparam int HW = bffa_pkg::HWM_W;
   localparam int IW = bffa_pkg::BIT_IDX_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(bffa_pkg::BITMAP_BYTES - 1);

   logic [2:0]    state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [31:0]   number_ff, number_in;
   logic [31:0]   base_block_ff, base_block_in;
   logic [AW-1:0] scan_addr_ff, scan_addr_in;
   logic [AW-1:0] data_addr_ff, data_addr_in;
   logic          data_vld_ff, data_vld_in;
   logic [HW-1:0] hwm_ff [2];
   logic [HW-1:0] hwm_in [2];
   logic [IW-1:0] bit_idx_ff, bit_idx_in;
   logic [1:0]    status_ff, status_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic [31:0]   rsp_alloc_number_ff, rsp_alloc_number_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic [31:0]   add_a, add_b, add_res;
   logic          add_sub;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, chk_addr;
   logic [7:0]    wr_data, eff_byte, free_mask;
   logic [7:0]    rd_data [2];
   logic          map_sel;
   logic [HW-1:0] hwm_sel;
   logic [2:0]    zero_pos;

   // Bitmap for data blocks (index 0) and for inodes (index 1).
   assign map_sel = op_ff[1];

   for (genvar g = 0; g < 2; g++) begin : g_map
      bffa_ram #(
         .WIDTH (8),
         .DEPTH (bffa_pkg::BITMAP_BYTES)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en && (map_sel == 1'(g))),
         .wr_addr (chk_addr),
         .wr_data (wr_data),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (rd_data[g])
      );
   end

   // Shared 32-bit add/subtract unit: free offset first, allocated number last.
   always_comb begin
      add_sub = 1'b0;
      add_a   = base_block_ff;
      add_b   = 32'(bit_idx_ff);
      if (state_ff == ST_OFFSET) begin
         add_sub = 1'b1;
         add_a   = number_ff;
         add_b   = (op_ff == bffa_pkg::REQ_FREE_BLOCK) ? base_block_ff : 32'd1;
      end else if (op_ff == bffa_pkg::REQ_ALLOC_INODE) begin
         add_a   = 32'd1;
      end
      add_res = add_sub ? (add_a - add_b) : (add_a + add_b);
   end

   // Bytes at or above the high-water mark were never written and read as zero.
   assign chk_addr  = (state_ff == ST_SCAN) ? data_addr_ff : number_ff[IW-1:3];
   assign hwm_sel   = hwm_ff[map_sel];
   assign eff_byte  = (HW'(chk_addr) >= hwm_sel) ? 8'h00 : rd_data[map_sel];
   assign free_mask = 8'(1) << number_ff[2:0];

   // Lowest clear bit of the byte under test.
   always_comb begin
      zero_pos = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (!eff_byte[i]) begin
            zero_pos = 3'(i);
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in            = state_ff;
      op_in               = op_ff;
      number_in           = number_ff;
      scan_addr_in        = scan_addr_ff;
      data_addr_in        = data_addr_ff;
      data_vld_in         = 1'b0;
      hwm_in              = hwm_ff;
      bit_idx_in          = bit_idx_ff;
      status_in           = status_ff;
      rsp_strobe_in       = 1'b0;
      rsp_alloc_number_in = rsp_alloc_number_ff;
      rsp_status_in       = rsp_status_ff;
      rd_en               = 1'b0;
      rd_addr             = scan_addr_ff;
      wr_en               = 1'b0;
      wr_data             = eff_byte & ~free_mask;
      base_block_in       = base_block_ff;

      if (csr_valid && csr_ready) begin
         base_block_in = csr_base_block;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in        = req_type;
               number_in    = req_item_number;
               scan_addr_in = '0;
               state_in     = req_type[0] ? ST_OFFSET : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // One read issued per cycle; data checked the cycle after.
            rd_en        = 1'b1;
            scan_addr_in = scan_addr_ff + AW'(1);
            data_addr_in = scan_addr_ff;
            data_vld_in  = 1'b1;
            if (data_vld_ff) begin
               if (eff_byte != 8'hFF) begin
                  wr_en       = 1'b1;
                  wr_data     = eff_byte | (8'(1) << zero_pos);
                  bit_idx_in  = {data_addr_ff, zero_pos};
                  status_in   = bffa_pkg::STAT_OK;
                  data_vld_in = 1'b0;
                  state_in    = ST_RESULT;
                  if (HW'(data_addr_ff) >= hwm_sel) begin
                     hwm_in[map_sel] = HW'(data_addr_ff) + HW'(1);
                  end
               end else if (data_addr_ff == LAST_ADDR) begin
                  status_in   = bffa_pkg::STAT_FULL;
                  data_vld_in = 1'b0;
                  state_in    = ST_RESULT;
               end
            end
         end
         ST_OFFSET: begin
            number_in = add_res;
            if (add_res >= 32'(bffa_pkg::POOL_BITS)) begin
               status_in = bffa_pkg::STAT_RANGE;
               state_in  = ST_RESULT;
            end else begin
               state_in  = ST_FREE_RD;
            end
         end
         ST_FREE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = number_ff[IW-1:3];
            state_in = ST_FREE_CHK;
         end
         ST_FREE_CHK: begin
            if ((eff_byte & free_mask) != 8'h00) begin
               wr_en     = 1'b1;
               status_in = bffa_pkg::STAT_OK;
            end else begin
               status_in = bffa_pkg::STAT_ALREADY_FREE;
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            rsp_strobe_in       = 1'b1;
            rsp_status_in       = status_ff;
            rsp_alloc_number_in = (!op_ff[0] && (status_ff == bffa_pkg::STAT_OK))
                                  ? add_res : 32'd0;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         data_vld_ff   <= 1'b0;
         hwm_ff[0]     <= '0;
         hwm_ff[1]     <= '0;
         base_block_ff <= 32'd0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         data_vld_ff   <= data_vld_in;
         hwm_ff        <= hwm_in;
         base_block_ff <= base_block_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff               <= op_in;
      number_ff           <= number_in;
      scan_addr_ff        <= scan_addr_in;
      data_addr_ff        <= data_addr_in;
      bit_idx_ff          <= bit_idx_in;
      status_ff           <= status_in;
      rsp_alloc_number_ff <= rsp_alloc_number_in;
      rsp_status_ff       <= rsp_status_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = (state_ff == ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_alloc_number = rsp_alloc_number_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

>>> rtl/bffa_checker.sv
module bffa_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [31:0] rsp_alloc_number,
   input logic [1:0]  rsp_status
);

   // A started transfer keeps the block busy in the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("start transfer did not raise busy");

   // A result closes the work, so busy is low while it is shown.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // Every result follows a busy cycle.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without preceding work");

   // No two results in consecutive cycles.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

   // Failed requests carry no number.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != bffa_pkg::STAT_OK) |-> rsp_alloc_number == 32'd0)
      else $error("nonzero number on a failed request");

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (.*);
